### hdl/scchar_pkg.sv
// ----------------------------------------------------------------------------
// scchar_pkg
// request codes, key codes and character helpers for the scancode translator
// ----------------------------------------------------------------------------
package scchar_pkg;

   // request codes carried on req_type
   localparam logic [1:0] REQ_SCAN = 2'd0;
   localparam logic [1:0] REQ_MAP  = 2'd1;
   localparam logic [1:0] REQ_POLL = 2'd2;

   // set-1 key codes of the modifier keys
   localparam logic [6:0] KEY_LSHIFT = 7'h2A;
   localparam logic [6:0] KEY_RSHIFT = 7'h36;
   localparam logic [6:0] KEY_CAPS   = 7'h3A;
   localparam logic [6:0] KEY_LCTRL  = 7'h1D;

   localparam logic [7:0] CTRL_MASK  = 8'h1F;
   localparam logic [7:0] CASE_DELTA = 8'd32;

   localparam int KEY_ADDR_W = 8;

   typedef logic [7:0] char_type;

   function automatic logic is_lower(input char_type c);
      return (c >= 8'h61) && (c <= 8'h7A);
   endfunction

   function automatic logic is_upper(input char_type c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   // caps swaps the case of letters, ctrl then folds letters to control codes
   function automatic char_type apply_mods(input char_type c, input logic caps,
                                           input logic ctrl);
      char_type r;
      r = c;
      if (caps) begin
         if (is_lower(c)) begin
            r = c - CASE_DELTA;
         end else if (is_upper(c)) begin
            r = c + CASE_DELTA;
         end
      end
      if (ctrl && (is_lower(r) || is_upper(r))) begin
         r = r & CTRL_MASK;
      end
      return r;
   endfunction

   // next value of an 8-bit press counter
   function automatic logic [7:0] count_step(input logic [7:0] cnt, input logic rel);
      logic [7:0] r;
      r = cnt;
      if (!rel) begin
         r = cnt + 8'd1;
      end else if (cnt != 8'd0) begin
         r = cnt - 8'd1;
      end
      return r;
   endfunction

endpackage

### hdl/scancode_to_char_with_modifiers.sv
// ----------------------------------------------------------------------------
// scancode_to_char_with_modifiers
// set-1 scancode to character translator with modifiers and a receive fifo
// ----------------------------------------------------------------------------
// usage
//   req channel: one beat per request, req_type picks the action
//     scan  - a raw scancode byte updates shift, ctrl and caps lock or, on a
//             key press, looks up a character and queues it
//     map   - writes one byte of the unshifted or shifted keymap
//     poll  - pops one character; only polls produce an rsp beat
//   rsp channel: rsp_char_valid is 1 with the character, or 0 with char 0
//     when the fifo was empty
//   throughput: one request per cycle while no held result stalls req
//   path: a poll result passes the lookup register, then the output register
//     (keymap and modifier state are written at the req edge, the lookup
//     result is registered, the fifo is read into the output register)
//   the fifo holds FIFO_DEPTH-1 characters; a character that finds it full
//     is dropped
//   stall: a result held on rsp only blocks req when the next poll waits
//     behind it; other requests keep flowing
//   reset: clears the modifiers, the fifo pointers and every keymap entry
//     (per-entry valid flags), no clearing pass is needed
// ----------------------------------------------------------------------------
module scancode_to_char_with_modifiers
   import scchar_pkg::*;
#(
   parameter int FIFO_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [7:0] req_scancode,
   input  logic [6:0] req_map_index,
   input  logic       req_map_shifted,
   input  logic [7:0] req_map_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_char_valid,
   output logic [7:0] rsp_char_out
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam int KEY_DEPTH = 2 ** KEY_ADDR_W;

   // ---------------------------------------------------------------- storage
   char_type               key_mem  [KEY_DEPTH];
   logic [KEY_DEPTH-1:0]   key_ok_ff, key_ok_in;
   char_type               fifo_mem [FIFO_DEPTH];

   // ---------------------------------------------------------------- state
   logic [7:0]       shift_ff, shift_in;
   logic [7:0]       ctrl_ff, ctrl_in;
   logic             caps_ff, caps_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;

   // lookup stage, loaded at the req beat
   logic             b_vld_ff, b_vld_in;
   logic             b_poll_ff;
   logic             b_caps_ff;
   logic             b_ctrl_ff;
   char_type         b_key_ff;
   logic             b_hit_ff;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   char_type         fifo_rd_ff;

   // ---------------------------------------------------------------- decode
   logic             req_fire;
   logic [6:0]       code;
   logic             rel;
   logic             is_shift, is_ctrl, is_caps;
   logic             is_press_key;
   logic [KEY_ADDR_W-1:0] rd_addr, wr_addr;
   logic             key_we;

   assign req_fire     = req_valid && req_ready;
   assign code         = req_scancode[6:0];
   assign rel          = req_scancode[7];
   assign is_shift     = (code == KEY_LSHIFT) || (code == KEY_RSHIFT);
   assign is_ctrl      = (code == KEY_LCTRL);
   assign is_caps      = (code == KEY_CAPS);
   assign is_press_key = !rel && !is_shift && !is_ctrl && !is_caps;
   // shifted half sits in the upper 128 entries
   assign rd_addr      = {(shift_ff != 8'd0), code};
   assign wr_addr      = {req_map_shifted, req_map_index};
   assign key_we       = req_fire && (req_type == REQ_MAP);

   // modifier tracking happens at the req beat, in request order
   always_comb begin
      shift_in = shift_ff;
      ctrl_in  = ctrl_ff;
      caps_in  = caps_ff;
      if (req_fire && (req_type == REQ_SCAN)) begin
         if (is_shift) begin
            shift_in = count_step(shift_ff, rel);
         end
         if (is_ctrl) begin
            ctrl_in = count_step(ctrl_ff, rel);
         end
         if (is_caps && !rel) begin
            caps_in = !caps_ff;
         end
      end
   end

   always_comb begin
      key_ok_in = key_ok_ff;
      if (key_we) begin
         key_ok_in[wr_addr] = 1'b1;
      end
   end

   // ---------------------------------------------------------------- fifo side
   logic             c_free;
   logic             b_move;
   logic             b_go;
   char_type         b_char;
   logic [PTR_W-1:0] head_next, tail_next;
   logic             fifo_full, fifo_empty;
   logic             push_go, poll_go, pop_go;

   assign c_free     = !rsp_valid_ff || rsp_ready;
   assign b_move     = !b_poll_ff || c_free;
   assign b_go       = b_vld_ff && b_move;
   assign req_ready  = !b_vld_ff || b_move;

   assign b_char     = apply_mods(b_key_ff, b_caps_ff, b_ctrl_ff);
   assign head_next  = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
   assign tail_next  = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
   assign fifo_full  = (head_next == tail_ff);
   assign fifo_empty = (head_ff == tail_ff);

   // an entry never written reads as no character
   assign push_go = b_go && !b_poll_ff && b_hit_ff && (b_key_ff != 8'd0) && !fifo_full;
   assign poll_go = b_go && b_poll_ff;
   assign pop_go  = poll_go && !fifo_empty;

   assign head_in = push_go ? head_next : head_ff;
   assign tail_in = pop_go ? tail_next : tail_ff;

   always_comb begin
      b_vld_in = b_go ? 1'b0 : b_vld_ff;
      if (req_fire) begin
         b_vld_in = (req_type == REQ_POLL) || ((req_type == REQ_SCAN) && is_press_key);
      end
   end

   always_comb begin
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || poll_go;
      rsp_hit_in   = poll_go ? !fifo_empty : rsp_hit_ff;
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         ctrl_ff      <= '0;
         caps_ff      <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         key_ok_ff    <= '0;
         b_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_hit_ff   <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         ctrl_ff      <= ctrl_in;
         caps_ff      <= caps_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         key_ok_ff    <= key_ok_in;
         b_vld_ff     <= b_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_hit_ff   <= rsp_hit_in;
      end
   end

   // keymap: one write and one registered read per beat
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= req_map_char;
      end
      if (req_fire) begin
         b_key_ff  <= key_mem[rd_addr];
         b_hit_ff  <= key_ok_ff[rd_addr];
         b_poll_ff <= (req_type == REQ_POLL);
         b_caps_ff <= caps_ff;
         b_ctrl_ff <= (ctrl_ff != 8'd0);
      end
   end

   // receive fifo: push at head, registered pop at tail
   always_ff @(posedge clock) begin
      if (push_go) begin
         fifo_mem[head_ff] <= b_char;
      end
      if (pop_go) begin
         fifo_rd_ff <= fifo_mem[tail_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_valid = rsp_hit_ff;
   assign rsp_char_out   = rsp_hit_ff ? fifo_rd_ff : 8'd0;

   // ---------------------------------------------------------------- checks
   a_push_fills : assert property (@(posedge clock) disable iff (reset)
      push_go |=> (head_ff != tail_ff))
      else $error("fifo empty after a push");

   a_empty_poll_keeps : assert property (@(posedge clock) disable iff (reset)
      (poll_go && fifo_empty) |=> ($stable(tail_ff) && !rsp_char_valid))
      else $error("empty poll moved the read pointer");

   a_ready_low_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (b_vld_ff && b_poll_ff && rsp_valid_ff && !rsp_ready))
      else $error("req stalled without a held result");

   a_caps_toggle : assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_type == REQ_SCAN) && (req_scancode == {1'b0, KEY_CAPS}))
      |=> (caps_ff != $past(caps_ff)))
      else $error("caps lock press did not toggle");

endmodule

### sim/scancode_to_char_with_modifiers_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_char_with_modifiers_tb
// self-checking bench for the scancode translator: a queue-fed req driver, a
// rsp monitor and a cycle-free model of keymap, modifiers and receive fifo
// that predicts every poll result in order of acceptance
// ----------------------------------------------------------------------------
module scancode_to_char_with_modifiers_tb
   import scchar_pkg::*;
();

   localparam int FIFO_DEPTH = 256;
   // req_type code that the block ignores
   localparam logic [1:0] REQ_NONE = 2'd3;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] scancode;
      logic [6:0] map_index;
      logic       map_shifted;
      logic [7:0] map_char;
   } req_item_type;

   typedef struct {
      logic       char_valid;
      logic [7:0] char_out;
   } poll_result_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [1:0] req_type        = REQ_POLL;
   logic [7:0] req_scancode    = 8'h00;
   logic [6:0] req_map_index   = 7'h00;
   logic       req_map_shifted = 1'b0;
   logic [7:0] req_map_char    = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;
   logic       rsp_char_valid;
   logic [7:0] rsp_char_out;

   // requests waiting for the driver, and poll results still owed by the dut
   req_item_type    pending_reqs[$];
   poll_result_type expected_polls[$];

   // model state: keymap (unshifted half then shifted half), modifiers, fifo
   logic [7:0] keymap[2*128];
   logic [7:0] shift_presses = 8'd0;
   logic [7:0] ctrl_presses  = 8'd0;
   logic       caps_lock     = 1'b0;
   logic [7:0] queued_chars[$];

   int n_sent = 0;
   int n_taken = 0;
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   logic [6:0] hot_keys[16];

   scancode_to_char_with_modifiers #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_scancode   (req_scancode),
      .req_map_index  (req_map_index),
      .req_map_shifted(req_map_shifted),
      .req_map_char   (req_map_char),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_valid (rsp_char_valid),
      .rsp_char_out   (rsp_char_out)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   // press counts up and wraps, release counts down but sticks at zero
   function automatic logic [7:0] press_count(input logic [7:0] cnt, input logic released);
      if (!released) begin
         return cnt + 8'd1;
      end
      return (cnt == 8'd0) ? cnt : cnt - 8'd1;
   endfunction

   // advance the model by one accepted req beat
   function automatic void translate_request(input req_item_type r);
      logic       released;
      logic [6:0] code;
      logic [7:0] c;
      poll_result_type res;
      case (r.kind)
         REQ_SCAN: begin
            released = r.scancode[7];
            code     = r.scancode[6:0];
            if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
               shift_presses = press_count(shift_presses, released);
            end else if (code == KEY_LCTRL) begin
               ctrl_presses = press_count(ctrl_presses, released);
            end else if (code == KEY_CAPS) begin
               if (!released) caps_lock = !caps_lock;
            end else if (!released) begin
               c = keymap[{shift_presses != 8'd0, code}];
               // a zero entry means the key has no character
               if (c != 8'd0) begin
                  // caps flips the case bit of letters only
                  if (caps_lock && is_letter(c)) c = c ^ 8'h20;
                  if (ctrl_presses != 8'd0 && is_letter(c)) c = c & CTRL_MASK;
                  // one slot is always left free, so a full fifo drops the char
                  if (queued_chars.size() < FIFO_DEPTH - 1) queued_chars.push_back(c);
               end
            end
         end
         REQ_MAP: begin
            keymap[{r.map_shifted, r.map_index}] = r.map_char;
         end
         REQ_POLL: begin
            if (queued_chars.size() == 0) begin
               res.char_valid = 1'b0;
               res.char_out   = 8'd0;
            end else begin
               res.char_valid = 1'b1;
               res.char_out   = queued_chars.pop_front();
            end
            expected_polls.push_back(res);
         end
         default: begin
            // unused request type, nothing happens
         end
      endcase
   endfunction

   // request builders; fields the request does not use carry random noise
   task automatic add_req(input logic [1:0] kind, input logic [7:0] sc,
                          input logic [6:0] idx, input logic sh, input logic [7:0] ch);
      req_item_type r;
      r.kind        = kind;
      r.scancode    = sc;
      r.map_index   = idx;
      r.map_shifted = sh;
      r.map_char    = ch;
      pending_reqs.push_back(r);
   endtask

   task automatic add_scan(input logic [7:0] sc);
      add_req(REQ_SCAN, sc, 7'($urandom), 1'($urandom), 8'($urandom));
   endtask

   task automatic add_map(input logic [6:0] idx, input logic sh, input logic [7:0] ch);
      add_req(REQ_MAP, 8'($urandom), idx, sh, ch);
   endtask

   task automatic add_poll();
      add_req(REQ_POLL, 8'($urandom), 7'($urandom), 1'($urandom), 8'($urandom));
   endtask

   // sender stays quiet until every queued request has gone and every poll
   // result has come back
   task automatic drain_all();
      while (pending_reqs.size() != 0 || n_sent != n_taken || expected_polls.size() != 0)
         @(negedge clock);
   endtask

   // mostly well-formed typing with random content, some noise on top
   task automatic add_random_items(input int count);
      int roll;
      logic [6:0] code;
      logic [7:0] ch;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < 30) begin
            code = ($urandom_range(3) != 0) ? hot_keys[4'($urandom_range(15))]
                                            : 7'($urandom);
            add_scan({($urandom_range(4) == 0), code});
         end else if (roll < 42) begin
            case ($urandom_range(3))
               0: code = KEY_LSHIFT;
               1: code = KEY_RSHIFT;
               2: code = KEY_LCTRL;
               default: code = KEY_CAPS;
            endcase
            add_scan({1'($urandom), code});
         end else if (roll < 57) begin
            code = ($urandom_range(3) != 0) ? hot_keys[4'($urandom_range(15))]
                                            : 7'($urandom);
            roll = $urandom_range(9);
            if (roll < 6) begin
               ch = 8'("A" + $urandom_range(25)) | (($urandom_range(1) != 0) ? 8'h20 : 8'h00);
            end else if (roll == 6) begin
               ch = 8'd0;
            end else begin
               ch = 8'($urandom);
            end
            add_map(code, 1'($urandom), ch);
         end else if (roll < 95) begin
            add_poll();
         end else begin
            add_req(REQ_NONE, 8'($urandom), 7'($urandom), 1'($urandom), 8'($urandom));
         end
      end
   endtask

   // driver: payload changes on the falling edge, held until its beat is taken
   always @(negedge clock) begin
      req_item_type r;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         // n_sent != n_taken while a presented beat is still waiting
         if (n_sent == n_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               r = pending_reqs.pop_front();
               req_valid       <= 1'b1;
               req_type        <= r.kind;
               req_scancode    <= r.scancode;
               req_map_index   <= r.map_index;
               req_map_shifted <= r.map_shifted;
               req_map_char    <= r.map_char;
               n_sent++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: both channels sampled on the rising edge
   always @(posedge clock) begin
      req_item_type r;
      poll_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            r.kind        = req_type;
            r.scancode    = req_scancode;
            r.map_index   = req_map_index;
            r.map_shifted = req_map_shifted;
            r.map_char    = req_map_char;
            translate_request(r);
            n_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_polls.size() == 0) begin
               $display("%0t: rsp beat with nothing expected, got valid %0b char %02h",
                        $time, rsp_char_valid, rsp_char_out);
               mismatch_count++;
            end else begin
               want = expected_polls.pop_front();
               if (rsp_char_valid !== want.char_valid) begin
                  $display("%0t: char_valid mismatch, expected %0b, got %0b",
                           $time, want.char_valid, rsp_char_valid);
                  mismatch_count++;
               end
               if (rsp_char_out !== want.char_out) begin
                  $display("%0t: char_out mismatch, expected %02h, got %02h",
                           $time, want.char_out, rsp_char_out);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      for (int i = 0; i < 2*128; i++) keymap[i] = 8'd0;
      for (int i = 0; i < 16; i++) hot_keys[i] = 7'($urandom);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty poll, table extremes, each modifier, zero entries
      add_poll();
      add_map(7'h1E, 1'b0, "a");
      add_map(7'h1E, 1'b1, "A");
      add_map(7'h00, 1'b0, 8'hFF);
      add_map(7'h7F, 1'b1, 8'h80);
      add_map(7'h02, 1'b1, "!");
      add_scan(8'h1E);                       // plain letter
      add_scan(8'h00);                       // lowest key, top char
      add_scan(8'h7F);                       // unmapped, nothing queued
      add_scan(8'h9E);                       // release of an ordinary key
      add_scan({1'b0, KEY_LSHIFT});
      add_scan(8'h1E);
      add_scan(8'h7F);                       // shifted top entry
      add_scan({1'b1, KEY_LSHIFT});
      add_scan({1'b1, KEY_RSHIFT});          // release at zero stays zero
      add_scan({1'b0, KEY_RSHIFT});
      add_scan(8'h02);
      add_scan({1'b1, KEY_RSHIFT});
      add_scan({1'b0, KEY_CAPS});
      add_scan({1'b1, KEY_CAPS});            // caps release does not toggle
      add_scan(8'h1E);
      add_scan({1'b0, KEY_LCTRL});
      add_scan(8'h1E);                       // caps then ctrl folds the letter
      add_scan(8'h00);                       // ctrl leaves non-letters alone
      add_scan({1'b1, KEY_LCTRL});
      add_scan({1'b0, KEY_CAPS});
      add_req(REQ_NONE, 8'h1E, 7'h7F, 1'b1, 8'hFF);
      repeat (9) add_poll();                 // drains, last one finds it empty
      drain_all();

      // full fifo: overfill by three, free one slot, overfill again, drain
      for (int k = 0; k < 10; k++) add_map(7'(8'h10 + k), 1'b0, 8'("a" + k));
      for (int k = 0; k < 258; k++) add_scan(8'(8'h10 + k % 10));
      add_poll();
      add_scan(8'h11);
      add_scan(8'h12);
      repeat (256) add_poll();
      drain_all();

      // random traffic under each idling pattern
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 50; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 50; end
            default: begin send_idle_pct = 35; rsp_stall_pct = 35; end
         endcase
         add_random_items(22);
         drain_all();
      end

      // allow slack for poll results still in flight
      repeat (10) @(negedge clock);
      if (expected_polls.size() != 0) begin
         $display("%0t: %0d poll results never arrived", $time, expected_polls.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
